// ===== design/hmf_pkg.sv =====
// Package for the frame median block: widths, saturation limit, state codes
// and the control bundle that drives the histogram walker.
// No dependencies; every other file of the block imports it.
package hmf_pkg;

    localparam int BIN_COUNT        = 256;
    localparam int BIN_AW           = $clog2(BIN_COUNT);
    localparam int PIX_W            = 8;
    localparam int CNT_W            = 23;
    // A running sum over all bins needs room for BIN_COUNT full bins.
    localparam int ACC_W            = CNT_W + BIN_AW;
    localparam int MAX_FRAME_PIXELS = 4194304;
    localparam int STATE_MAX        = (2 ** CNT_W) - 1;

    localparam logic [CNT_W-1:0] SAT_LIMIT =
        (MAX_FRAME_PIXELS > STATE_MAX) ? CNT_W'(STATE_MAX) : CNT_W'(MAX_FRAME_PIXELS);

    localparam logic [BIN_AW-1:0] BIN_LAST = BIN_AW'(BIN_COUNT - 1);
    localparam logic [PIX_W-1:0]  MEDIAN_NONE = '1;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic              start;
        logic              bin_valid;
        logic [BIN_AW-1:0] bin_index;
    } walk_ctl_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v >= SAT_LIMIT)
            r = SAT_LIMIT;
        else
            r = v + CNT_W'(1);
        return r;
    endfunction

endpackage

// ===== design/hmf_bin_ram.sv =====
// Histogram bin memory: one write port and one read port, read data registered.
// Depends on hmf_pkg for the depth and the bin width.
module hmf_bin_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [hmf_pkg::BIN_AW-1:0] waddr,
    input  logic [hmf_pkg::CNT_W-1:0]  wdata,
    input  logic [hmf_pkg::BIN_AW-1:0] raddr,
    output logic [hmf_pkg::CNT_W-1:0]  rdata
);
    import hmf_pkg::*;

    logic [CNT_W-1:0] mem [BIN_COUNT];
    logic [CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/hmf_walker.sv =====
// Median search: accumulates the bins in address order and latches the first
// index whose running total reaches the target. Depends on hmf_pkg.
module hmf_walker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hmf_pkg::walk_ctl_t          ctl,
    input  logic [hmf_pkg::CNT_W-1:0]   bin_data,
    input  logic [hmf_pkg::CNT_W-2:0]   target,
    output logic [hmf_pkg::PIX_W-1:0]   median
);
    import hmf_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             found_reg, found_next;
    logic [PIX_W-1:0] median_reg, median_next;
    logic [ACC_W-1:0] sum;

    assign sum = acc_reg + ACC_W'(bin_data);

    always_comb
    begin
        acc_next    = acc_reg;
        found_next  = found_reg;
        median_next = median_reg;
        if (ctl.start)
        begin
            acc_next    = '0;
            found_next  = 1'b0;
            median_next = MEDIAN_NONE;
        end
        else if (ctl.bin_valid)
        begin
            acc_next = sum;
            if (!found_reg && (sum >= ACC_W'(target)))
            begin
                found_next  = 1'b1;
                median_next = PIX_W'(ctl.bin_index);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            found_reg  <= 1'b0;
            median_reg <= '0;
        end
        else
        begin
            acc_reg    <= acc_next;
            found_reg  <= found_next;
            median_reg <= median_next;
        end
    end

    assign median = median_reg;

endmodule

// ===== design/histogram_median_of_frame.sv =====
// Frame median by 256-bin histogram, top level.
// Depends on hmf_pkg, hmf_bin_ram and hmf_walker.
//
// Usage: the input channel (in_valid/in_ready) carries one pixel per item with
// pixel_valid and frame_end flags; the output channel (out_valid/out_ready)
// carries one median and pixel_total per frame. Inside a frame one item is
// accepted every cycle; each pixel does a read-modify-write of its bin in the
// bin memory, and a write register forwards the last bin value so equal
// pixels in consecutive cycles count correctly.
// An item with frame_end set closes the frame: the input stops while the block
// passes through the drain state, a walk over the memory read port that also
// clears each bin, and the finish state, which sums and clears the last bin and
// then loads the result, after which the result is shown and the next item can be accepted.
// The result sits in an output register, so the next frame streams in while
// it waits; if the receiver still stalls at the end of the next walk, the
// block holds before loading the new result.
// After reset the block clears every bin of the memory before
// in_ready first rises.
module histogram_median_of_frame (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hmf_pkg::PIX_W-1:0]  pixel,
    input  logic                       pixel_valid,
    input  logic                       frame_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hmf_pkg::PIX_W-1:0]  median,
    output logic [hmf_pkg::CNT_W-1:0]  pixel_total
);
    import hmf_pkg::*;

    state_t            state_reg, state_next;
    logic [BIN_AW-1:0] sweep_reg, sweep_next;

    logic              pix_s1_valid_reg;
    logic [BIN_AW-1:0] pix_s1_addr_reg;
    logic              fwd_valid_reg;
    logic [BIN_AW-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]  fwd_data_reg;
    logic              walk_s1_valid_reg;
    logic [BIN_AW-1:0] walk_s1_addr_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  median_out_reg;
    logic [CNT_W-1:0]  total_out_reg;

    logic              in_accept;
    logic              load_out;
    logic              ram_we;
    logic [BIN_AW-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [BIN_AW-1:0] ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]  bin_cur;
    logic [CNT_W-1:0]  bin_inc;
    walk_ctl_t         walk_ctl;
    logic [PIX_W-1:0]  walk_median;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // The previous cycle's write lands at the same edge as this read, so the
    // memory returns stale data for a repeated bin; take the written value.
    assign bin_cur = (fwd_valid_reg && (fwd_addr_reg == pix_s1_addr_reg)) ?
                     fwd_data_reg : ram_rdata;
    assign bin_inc = sat_inc(bin_cur);

    assign ram_raddr = (state_reg == ST_WALK) ? sweep_reg : BIN_AW'(pixel);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pix_s1_addr_reg;
        ram_wdata = bin_inc;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = '0;
        end
        else if (walk_s1_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = walk_s1_addr_reg;
            ram_wdata = '0;
        end
        else if (pix_s1_valid_reg)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + BIN_AW'(1);
                if (sweep_reg == BIN_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_accept && frame_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                sweep_next = sweep_reg + BIN_AW'(1);
                if (sweep_reg == BIN_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!walk_s1_valid_reg && (!out_valid_reg || out_ready))
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                sweep_next = '0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (load_out)
            count_next = '0;
        else if (in_accept && pixel_valid)
            count_next = sat_inc(count_reg);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign walk_ctl.start     = (state_reg == ST_DRAIN);
    assign walk_ctl.bin_valid = walk_s1_valid_reg;
    assign walk_ctl.bin_index = walk_s1_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            sweep_reg         <= '0;
            pix_s1_valid_reg  <= 1'b0;
            fwd_valid_reg     <= 1'b0;
            walk_s1_valid_reg <= 1'b0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sweep_reg         <= sweep_next;
            pix_s1_valid_reg  <= in_accept && pixel_valid;
            fwd_valid_reg     <= pix_s1_valid_reg;
            walk_s1_valid_reg <= (state_reg == ST_WALK);
            count_reg         <= count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_s1_addr_reg  <= BIN_AW'(pixel);
        fwd_addr_reg     <= pix_s1_addr_reg;
        fwd_data_reg     <= bin_inc;
        walk_s1_addr_reg <= sweep_reg;
        if (load_out)
        begin
            median_out_reg <= walk_median;
            total_out_reg  <= count_reg;
        end
    end

    hmf_bin_ram u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hmf_walker u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (walk_ctl),
        .bin_data (ram_rdata),
        .target   (count_reg[CNT_W-1:1]),
        .median   (walk_median)
    );

    assign out_valid   = out_valid_reg;
    assign median      = median_out_reg;
    assign pixel_total = total_out_reg;

endmodule

// ===== design/hmf_checker.sv =====
// Port-level checks for the frame median block, bound to its top level.
// Depends on hmf_pkg and histogram_median_of_frame.
module hmf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       frame_end,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [hmf_pkg::PIX_W-1:0]  median,
    input logic [hmf_pkg::CNT_W-1:0]  pixel_total
);
    import hmf_pkg::*;

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median) && $stable(pixel_total))
        else $error("result changed while stalled");

    // Closing a frame moves the block to its drain state, so input stops on the next cycle.
    a_frame_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && frame_end |=> !in_ready)
        else $error("input accepted right after frame end");

    // An empty frame reports intensity zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_total != '0) || (median == '0))
        else $error("empty frame with nonzero median");

    // With a single pixel the target is zero, so the first bin is taken.
    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pixel_total == CNT_W'(1)) |-> (median == '0))
        else $error("one-pixel frame with nonzero median");

endmodule

bind histogram_median_of_frame hmf_checker u_hmf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .median      (median),
    .pixel_total (pixel_total)
);

// ===== tb/hmf_median_checker.sv =====
`timescale 1ns / 100ps
// Checker for the frame median block: watches both channels, predicts each
// frame's median and pixel total from its own histogram and compares them.
// Depends on hmf_pkg for widths and the frame pixel limit.
module hmf_median_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [hmf_pkg::PIX_W-1:0] pixel,
    input  logic                      pixel_valid,
    input  logic                      frame_end,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [hmf_pkg::PIX_W-1:0] median,
    input  logic [hmf_pkg::CNT_W-1:0] pixel_total,
    output int                        mismatches,
    output int                        awaited,
    output int                        frames_checked
);
    import hmf_pkg::*;

    // Counts stop at the frame limit, or at the top of the counter if the
    // limit does not fit.
    localparam logic [CNT_W-1:0] PIXEL_CAP =
        (MAX_FRAME_PIXELS > (2 ** CNT_W) - 1) ? '1 : CNT_W'(MAX_FRAME_PIXELS);

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic [CNT_W-1:0] total;
    } frame_result_t;

    logic [CNT_W-1:0] bin_tally [BIN_COUNT];
    logic [CNT_W-1:0] pixel_tally;
    frame_result_t    pending_frames [$];
    frame_result_t    want;

    function automatic logic [CNT_W-1:0] capped_inc(input logic [CNT_W-1:0] v);
        return (v >= PIXEL_CAP) ? PIXEL_CAP : v + 1'b1;
    endfunction

    // Walk the histogram from the darkest bin and stop at the first one where
    // the running total reaches half the pixel count, rounded down.
    function automatic frame_result_t close_frame();
        frame_result_t r;
        longint        running;
        longint        half;
        bit            found;
        r.total = pixel_tally;
        r.median = '0;
        if (pixel_tally != '0)
        begin
            half = longint'(pixel_tally >> 1);
            running = 0;
            found = 1'b0;
            r.median = '1;
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                if (!found)
                begin
                    running += longint'(bin_tally[i]);
                    if (running >= half)
                    begin
                        r.median = PIX_W'(i);
                        found = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report(input string msg);
        if (mismatches < 10)
            $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
                bin_tally[i] = '0;
            pixel_tally = '0;
            pending_frames.delete();
            mismatches = 0;
            awaited = 0;
            frames_checked = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (pixel_valid)
                begin
                    bin_tally[pixel] = capped_inc(bin_tally[pixel]);
                    pixel_tally = capped_inc(pixel_tally);
                end
                if (frame_end)
                begin
                    pending_frames.insert(pending_frames.size(), close_frame());
                    for (int i = 0; i < BIN_COUNT; i++)
                        bin_tally[i] = '0;
                    pixel_tally = '0;
                end
            end
            if (out_valid && out_ready)
            begin
                if (pending_frames.size() == 0)
                    report($sformatf("result with no closed frame: median %0d, total %0d",
                                     median, pixel_total));
                else
                begin
                    want = pending_frames.pop_front();
                    if (median !== want.median)
                        report($sformatf("frame %0d median: expected %0d, got %0d",
                                         frames_checked, want.median, median));
                    if (pixel_total !== want.total)
                        report($sformatf("frame %0d pixel_total: expected %0d, got %0d",
                                         frames_checked, want.total, pixel_total));
                end
                frames_checked++;
            end
            awaited = pending_frames.size();
        end
    end

endmodule

// ===== tb/tb_histogram_median_of_frame.sv =====
`timescale 1ns / 100ps
// Testbench top for the frame median block: makes directed and random frames,
// paces both channels and gives the verdict.
// Depends on hmf_pkg, histogram_median_of_frame and hmf_median_checker.
module tb_histogram_median_of_frame;
    import hmf_pkg::*;

    localparam int RANDOM_ITEMS  = 1530;
    localparam int LONG_HOLD     = 2000;
    localparam int SETTLE_CYCLES = 300;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [PIX_W-1:0] pixel;
    logic             pixel_valid;
    logic             frame_end;
    logic             out_valid;
    logic             out_ready;
    logic [PIX_W-1:0] median;
    logic [CNT_W-1:0] pixel_total;

    int mismatches;
    int awaited;
    int frames_checked;

    int burst_left   = 0;
    int items_sent   = 0;
    int frames_sent  = 0;
    int large_frames = 0;
    int hold_left    = 0;
    int ready_run    = 0;
    int stall_run    = 0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    histogram_median_of_frame dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .median      (median),
        .pixel_total (pixel_total)
    );

    hmf_median_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel          (pixel),
        .pixel_valid    (pixel_valid),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .median         (median),
        .pixel_total    (pixel_total),
        .mismatches     (mismatches),
        .awaited        (awaited),
        .frames_checked (frames_checked)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic push_item(input logic [PIX_W-1:0] px, input logic pv, input logic fe);
        in_valid    <= 1'b1;
        pixel       <= px;
        pixel_valid <= pv;
        frame_end   <= fe;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (fe)
            frames_sent++;
    endtask

    // Bursts of random length; between bursts the sender usually rests a while.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    task automatic random_frame();
        int               len;
        int               style;
        bit               empty_close;
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] px;
        logic             pv;
        case ($urandom_range(0, 19))
            0: len = 0;
            1: len = 1;
            2: len = $urandom_range(150, 320);
            default: len = $urandom_range(2, 24);
        endcase
        if (len > 100)
            large_frames++;
        style = $urandom_range(0, 3);
        base = PIX_W'($urandom);
        empty_close = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++)
        begin
            case (style)
                0: px = PIX_W'($urandom);
                1: px = base + PIX_W'($urandom_range(0, 7));
                2: px = ($urandom_range(0, 1) != 0) ? '1 : '0;
                default: px = PIX_W'(255 - $urandom_range(0, 3));
            endcase
            // About one item in ten carries no pixel.
            pv = ($urandom_range(0, 9) != 0);
            pace();
            push_item(px, pv, (k == len - 1) && !empty_close);
        end
        if (empty_close)
        begin
            pace();
            push_item(PIX_W'($urandom), 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pixel       = '0;
        pixel_valid = 1'b0;
        frame_end   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Frame with no pixel at all, with and without ignored items ahead.
        push_item(8'hFF, 1'b0, 1'b1);
        push_item(8'h55, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        // A single pixel reports zero whatever its value, and so do pixels 00 and FF together.
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1);
        // The walk has to run to the brightest bin; closed by an empty item.
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h07, 1'b0, 1'b0);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h40, 1'b1, 1'b0);
        push_item(8'hC8, 1'b1, 1'b0);
        push_item(8'hAA, 1'b0, 1'b0);
        push_item(8'h80, 1'b1, 1'b1);
        // Equal pixels back to back hit the same bin on consecutive cycles.
        push_item(8'h03, 1'b1, 1'b0);
        push_item(8'h03, 1'b1, 1'b0);
        push_item(8'h03, 1'b1, 1'b0);
        push_item(8'h09, 1'b1, 1'b0);
        push_item(8'h09, 1'b1, 1'b1);
        wait_drained();

        while (items_sent < RANDOM_ITEMS + 20)
        begin
            if (frames_sent == 18)
                hold_request = 1'b1;
            if (frames_sent % 37 == 36)
                wait_drained();
            random_frame();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d items in %0d frames, %0d of them large.",
                 items_sent, frames_sent, large_frames);
        $display("%0d frame results were compared.", frames_checked);
        if (mismatches == 0 && awaited == 0)
            $display("PASSED: all results match");
        else
        begin
            if (awaited != 0)
                $display("%0d frame results never arrived", awaited);
            $display("FAILED: results differ");
        end
        $finish;
    end

    // The receiver alternates ready runs and stalls, and once holds off long
    // enough for the block to back up into its input.
    initial
    begin
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (ready_run > 0)
            begin
                out_ready <= 1'b1;
                ready_run--;
            end
            else if (stall_run > 0)
            begin
                out_ready <= 1'b0;
                stall_run--;
            end
            else
            begin
                ready_run = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 800)
                                                        : $urandom_range(1, 30);
                stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("Timeout with %0d frame results outstanding", awaited);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/hmf_pkg.sv
design/hmf_bin_ram.sv
design/hmf_walker.sv
design/histogram_median_of_frame.sv
design/hmf_checker.sv
tb/hmf_median_checker.sv
tb/tb_histogram_median_of_frame.sv
